// ----- rtl/core/convolution_3x3_valid_top_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the 3x3 valid-mode convolution block
// Concurrent assertion wrappers that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef CONVOLUTION_3X3_VALID_TOP_DEFINES_SVH
`define CONVOLUTION_3X3_VALID_TOP_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication checked on every rising edge outside reset.
`define CONV3_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked on every rising edge outside reset.
`define CONV3_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CONV3_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define CONV3_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ----- rtl/core/conv3_pkg.sv -----
// ----------------------------------------------------------------------------
// conv3_pkg
// Shared widths, register indexes, types and helpers of the 3x3 filter.
// ----------------------------------------------------------------------------
package conv3_pkg;

  localparam int PIX_W     = 8;
  localparam int SUM_W     = 28;
  localparam int IDX_W     = 10;
  localparam int KROW_W    = 48;
  localparam int SIZE_W    = 11;
  localparam int CFG_IDX_W = 3;
  // Compare width for positions and sizes; covers sizes up to 4096.
  localparam int POS_CMP_W = 13;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_TAP_BITS   = 16;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_TOP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MIDDLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_BOTTOM = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd4;

  // Control handed from the top level to each window cell.
  typedef struct packed {
    logic en;     // whole pipeline advances this cycle
    logic shift;  // a pixel column enters the window this cycle
  } cell_ctrl_t;

  // Limits a programmed size to the range three up to hi.
  function automatic logic [POS_CMP_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                      input logic [POS_CMP_W-1:0] hi);
    logic [POS_CMP_W-1:0] ext;
    ext = {{(POS_CMP_W-SIZE_W){1'b0}}, v};
    if (ext < POS_CMP_W'(3)) begin
      return POS_CMP_W'(3);
    end else if (ext > hi) begin
      return hi;
    end
    return ext;
  endfunction

endpackage

// ----- rtl/core/conv3_line_store.sv -----
// ----------------------------------------------------------------------------
// conv3_line_store
// Single-port-pair line memory holding the two previous rows per column,
// with a registered read and forwarding of the write made on the read edge.
// ----------------------------------------------------------------------------
module conv3_line_store #(
  parameter int DEPTH  = conv3_pkg::DEF_MAX_WIDTH,
  parameter int DATA_W = 2 * conv3_pkg::PIX_W,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] mem_q;
  logic [ADDR_W-1:0] rd_addr_q;
  logic [ADDR_W-1:0] last_addr;
  logic [DATA_W-1:0] last_data;
  logic              last_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q     <= mem[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  // The most recent write; a read taken on the same edge missed it.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_vld <= 1'b0;
    end else if (wr_en) begin
      last_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      last_addr <= wr_addr;
      last_data <= wr_data;
    end
  end

  assign rd_data = (last_vld && (last_addr == rd_addr_q)) ? last_data : mem_q;

endmodule

// ----- rtl/core/conv3_cell.sv -----
// ----------------------------------------------------------------------------
// conv3_cell
// One column of the 3x3 window: holds three pixels, passes them on to its
// neighbor and forms the weighted sum of the column entering it.
// ----------------------------------------------------------------------------
`include "convolution_3x3_valid_top_defines.svh"

module conv3_cell #(
  parameter int TAP_BITS = conv3_pkg::DEF_TAP_BITS,
  localparam int PROD_W = TAP_BITS + conv3_pkg::PIX_W + 1,
  localparam int PART_W = PROD_W + 2
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  conv3_pkg::cell_ctrl_t                ctrl,
  input  logic [2:0][conv3_pkg::PIX_W-1:0]     col_in,
  input  logic [2:0][TAP_BITS-1:0]             taps,
  output logic [2:0][conv3_pkg::PIX_W-1:0]     col_out,
  output logic signed [PART_W-1:0]             partial
);

  logic [2:0][conv3_pkg::PIX_W-1:0] col_q;
  logic signed [PROD_W-1:0]         prod_q [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      col_q <= '0;
    end else if (ctrl.shift) begin
      col_q <= col_in;
    end
  end

  // Products of the column that enters this cycle, then their column sum.
  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      for (int u = 0; u < 3; u++) begin
        prod_q[u] <= $signed({1'b0, col_in[u]}) * $signed(taps[u]);
      end
      partial <= PART_W'(prod_q[0]) + PART_W'(prod_q[1]) + PART_W'(prod_q[2]);
    end
  end

  assign col_out = col_q;

  `CONV3_ASSERT_IMP(a_shift_needs_en, clk, rst, ctrl.shift, ctrl.en, "window shift while stalled")

endmodule

// ----- rtl/core/convolution_3x3_valid_top.sv -----
// ----------------------------------------------------------------------------
// convolution_3x3_valid_top
// 3x3 valid-mode filter over a raster pixel stream with two line stores.
// ----------------------------------------------------------------------------
// The block takes one unsigned 8-bit pixel per clock in raster order, while
// the result side keeps up, and returns, for every pixel at row two or more
// and column two or more, the signed sum of the 3x3 window times the programmed
// kernel (correlation order: the top-left tap weights the oldest pixel). Each
// pixel passes stage 1, the cell product and sum stages and the output
// register on the way to its result; the pixel rate is set by the line memory,
// which is read once and written once per pixel. The user must write kernel
// rows and image sizes through the configuration port only while the block
// is idle; the block itself does not enforce this. Sizes are limited to three
// up to MAX_WIDTH and MAX_HEIGHT. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
`include "convolution_3x3_valid_top_defines.svh"

module convolution_3x3_valid_top #(
  parameter int MAX_WIDTH  = conv3_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = conv3_pkg::DEF_MAX_HEIGHT,
  parameter int TAP_BITS   = conv3_pkg::DEF_TAP_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // Configuration write channel.
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [conv3_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [conv3_pkg::KROW_W-1:0]          cfg_data,
  // Pixel input channel.
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [conv3_pkg::PIX_W-1:0]           pixel,
  input  logic                                  frame_start,
  // Result output channel.
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [conv3_pkg::SUM_W-1:0]    sum,
  output logic [conv3_pkg::IDX_W-1:0]           out_row,
  output logic [conv3_pkg::IDX_W-1:0]           out_col,
  output logic                                  frame_end
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int CMP_W  = conv3_pkg::POS_CMP_W;
  localparam int PIX_W  = conv3_pkg::PIX_W;
  localparam int IDX_W  = conv3_pkg::IDX_W;
  localparam int SUM_W  = conv3_pkg::SUM_W;
  localparam int PART_W = TAP_BITS + PIX_W + 3;

  // --------------------------------------------------------------------------
  // Configuration registers. The port never stalls.
  // --------------------------------------------------------------------------
  logic [conv3_pkg::KROW_W-1:0] kernel_row [3];
  logic [conv3_pkg::SIZE_W-1:0] image_width;
  logic [conv3_pkg::SIZE_W-1:0] image_height;
  logic [CMP_W-1:0]             w_lim;
  logic [CMP_W-1:0]             h_lim;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_row[0] <= '0;
      kernel_row[1] <= '0;
      kernel_row[2] <= '0;
      image_width   <= conv3_pkg::SIZE_RESET;
      image_height  <= conv3_pkg::SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        conv3_pkg::REG_KERNEL_TOP:    kernel_row[0] <= cfg_data;
        conv3_pkg::REG_KERNEL_MIDDLE: kernel_row[1] <= cfg_data;
        conv3_pkg::REG_KERNEL_BOTTOM: kernel_row[2] <= cfg_data;
        conv3_pkg::REG_IMAGE_WIDTH:   image_width   <= cfg_data[conv3_pkg::SIZE_W-1:0];
        conv3_pkg::REG_IMAGE_HEIGHT:  image_height  <= cfg_data[conv3_pkg::SIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The sizes in use follow the size registers directly, so a pixel taken in
  // the cycle right after a size write already sees the new size.
  assign w_lim = conv3_pkg::clamp_size(image_width, CMP_W'(MAX_WIDTH));
  assign h_lim = conv3_pkg::clamp_size(image_height, CMP_W'(MAX_HEIGHT));

  // --------------------------------------------------------------------------
  // Pipeline enable. All stages advance together whenever the output register
  // is empty or being emptied; a held result stalls the whole pipeline and
  // the input with it.
  // --------------------------------------------------------------------------
  logic en;
  logic accept;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign accept   = in_valid && in_ready;

  // --------------------------------------------------------------------------
  // Position tracking at acceptance. A frame start or a size shrunk in mid
  // frame first moves the position; then the pixel is placed, and the
  // position steps on, wrapping at the row end and at the frame end.
  // --------------------------------------------------------------------------
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [CMP_W-1:0] c0, r0, c1, r1, r2, cn, rn;
  logic             wrap_in, wrap_out;
  logic [COL_W-1:0] col_next;
  logic [ROW_W-1:0] row_next;
  logic             produce;
  logic             last_px;
  logic [CMP_W-1:0] row_ofs, col_ofs;

  always_comb begin
    c0       = frame_start ? '0 : {{(CMP_W-COL_W){1'b0}}, col};
    r0       = frame_start ? '0 : {{(CMP_W-ROW_W){1'b0}}, row};
    wrap_in  = c0 >= w_lim;
    c1       = wrap_in ? '0 : c0;
    r1       = wrap_in ? r0 + CMP_W'(1) : r0;
    r2       = (r1 >= h_lim) ? '0 : r1;
    cn       = c1 + CMP_W'(1);
    rn       = r2 + CMP_W'(1);
    wrap_out = cn >= w_lim;
    col_next = wrap_out ? '0 : cn[COL_W-1:0];
    if (!wrap_out) begin
      row_next = r2[ROW_W-1:0];
    end else if (rn >= h_lim) begin
      row_next = '0;
    end else begin
      row_next = rn[ROW_W-1:0];
    end
    produce = (r2 >= CMP_W'(2)) && (c1 >= CMP_W'(2));
    last_px = (r2 == h_lim - CMP_W'(1)) && (c1 == w_lim - CMP_W'(1));
    row_ofs = r2 - CMP_W'(2);
    col_ofs = c1 - CMP_W'(2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: the line memory read is in flight; the pixel and the result tags
  // wait beside it.
  // --------------------------------------------------------------------------
  logic             s1_vld, s1_prod, s1_end;
  logic [PIX_W-1:0] s1_px;
  logic [COL_W-1:0] s1_addr;
  logic [IDX_W-1:0] s1_row, s1_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px   <= pixel;
      s1_addr <= c1[COL_W-1:0];
      s1_prod <= produce;
      s1_end  <= last_px;
      s1_row  <= row_ofs[IDX_W-1:0];
      s1_col  <= col_ofs[IDX_W-1:0];
    end
  end

  // Each entry packs the pixel two rows up (high byte) and one row up (low
  // byte). Writing back {one row up, new pixel} shifts the column by a row.
  logic [2*PIX_W-1:0] ls_rd;
  logic [PIX_W-1:0]   above2, above1;
  logic               ls_we;

  assign above2 = ls_rd[2*PIX_W-1:PIX_W];
  assign above1 = ls_rd[PIX_W-1:0];
  assign ls_we  = s1_vld && en;

  conv3_line_store #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (2 * PIX_W)
  ) u_line_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (c1[COL_W-1:0]),
    .wr_en   (ls_we),
    .wr_addr (s1_addr),
    .wr_data ({above1, s1_px}),
    .rd_data (ls_rd)
  );

  // --------------------------------------------------------------------------
  // Window: a chain of three column cells. The newest column enters cell 2
  // and older columns move toward cell 0 (the left kernel taps). Each cell
  // registers its three products (stage 2) and then their sum (stage 3).
  // --------------------------------------------------------------------------
  conv3_pkg::cell_ctrl_t        ctrl;
  logic [2:0][PIX_W-1:0]        win_in  [3];
  logic [2:0][PIX_W-1:0]        win_out [3];
  logic [2:0][TAP_BITS-1:0]     taps    [3];
  logic signed [PART_W-1:0]     partial [3];

  assign ctrl.en    = en;
  assign ctrl.shift = s1_vld && en;

  for (genvar v = 0; v < 3; v++) begin : g_cell
    for (genvar u = 0; u < 3; u++) begin : g_tap
      assign taps[v][u] = kernel_row[u][v*TAP_BITS +: TAP_BITS];
    end

    if (v == 2) begin : g_head
      assign win_in[v] = {s1_px, above1, above2};
    end else begin : g_link
      assign win_in[v] = win_out[v+1];
    end

    conv3_cell #(
      .TAP_BITS (TAP_BITS)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .col_in  (win_in[v]),
      .taps    (taps[v]),
      .col_out (win_out[v]),
      .partial (partial[v])
    );
  end

  // Result tags follow the products through stages 2 and 3.
  logic             s2_vld, s2_end, s3_vld, s3_end;
  logic [IDX_W-1:0] s2_row, s2_col, s3_row, s3_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld    <= 1'b0;
      s3_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s2_vld    <= s1_vld && s1_prod;
      s3_vld    <= s2_vld;
      out_valid <= s3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_end    <= s1_end;
      s2_row    <= s1_row;
      s2_col    <= s1_col;
      s3_end    <= s2_end;
      s3_row    <= s2_row;
      s3_col    <= s2_col;
      frame_end <= s3_end;
      out_row   <= s3_row;
      out_col   <= s3_col;
      sum       <= SUM_W'(partial[0]) + SUM_W'(partial[1]) + SUM_W'(partial[2]);
    end
  end

  `CONV3_ASSERT_NXT(a_accept_enters, clk, rst, accept, s1_vld, "accepted item missing in stage 1")
  `CONV3_ASSERT_NXT(a_stall_keeps_s1, clk, rst, s1_vld && !en, s1_vld, "stalled item lost")
  `CONV3_ASSERT_IMP(a_result_source, clk, rst, out_valid && !$past(out_valid), $past(s3_vld), "result without source")

endmodule

// ----- test/convolution_3x3_valid_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// convolution_3x3_valid_top_test
// Self-checking bench for the 3x3 valid-mode filter on a raster pixel stream.
// A queue-fed driver sends pixels with random gaps. A monitor with random
// back-pressure compares each result with a software copy of the filter that
// is updated as pixels are accepted. Kernel rows and image sizes are changed
// between phases, and a few phases also resize in the middle of a frame.
// ----------------------------------------------------------------------------
module convolution_3x3_valid_top_test;

  localparam int TAP_W          = conv3_pkg::DEF_TAP_BITS;
  localparam int PIX_W          = conv3_pkg::PIX_W;
  localparam int SUM_W          = conv3_pkg::SUM_W;
  localparam int IDX_W          = conv3_pkg::IDX_W;
  localparam int CFG_IDX_W      = conv3_pkg::CFG_IDX_W;
  localparam int KROW_W         = conv3_pkg::KROW_W;
  localparam int SIZE_W         = conv3_pkg::SIZE_W;
  localparam int DEF_MAX_WIDTH  = conv3_pkg::DEF_MAX_WIDTH;
  localparam int DEF_MAX_HEIGHT = conv3_pkg::DEF_MAX_HEIGHT;

  typedef struct {
    logic [PIX_W-1:0] px;
    logic             fs;
  } pixel_item_t;

  typedef struct {
    logic signed [SUM_W-1:0] sum;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic                    last;
  } window_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [KROW_W-1:0]     cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [PIX_W-1:0]      pixel = '0;
  logic                  frame_start = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic signed [SUM_W-1:0] sum;
  logic [IDX_W-1:0]      out_row;
  logic [IDX_W-1:0]      out_col;
  logic                  frame_end;

  // Items waiting to be sent, and results the filter copy says must come back.
  pixel_item_t    pixels_pending[$];
  window_result_t sums_due[$];

  // Software copy of the filter: configuration, line memories, window and
  // raster position. The seen flags record which line entries hold a real
  // pixel, so a resize in mid frame never makes the block read a stale entry.
  logic [KROW_W-1:0] taps_row[3];
  logic [SIZE_W-1:0] width_cfg;
  logic [SIZE_W-1:0] height_cfg;
  logic [PIX_W-1:0]  upper_line[DEF_MAX_WIDTH];
  logic [PIX_W-1:0]  lower_line[DEF_MAX_WIDTH];
  bit                upper_seen[DEF_MAX_WIDTH];
  bit                lower_seen[DEF_MAX_WIDTH];
  logic [PIX_W-1:0]  win[3][3];
  int                col_at;
  int                row_at;

  // Per-phase switches: when set, that side never idles.
  bit steady_in;
  bit steady_out;
  int mismatches;

  convolution_3x3_valid_top DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pixel       (pixel),
    .frame_start (frame_start),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .sum         (sum),
    .out_row     (out_row),
    .out_col     (out_col),
    .frame_end   (frame_end)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Sizes outside three up to the maximum are pinned to the nearest limit.
  function automatic int fit_dim(input logic [SIZE_W-1:0] v, input int hi);
    if (v < 3) begin
      return 3;
    end else if (v > hi) begin
      return hi;
    end
    return int'(v);
  endfunction

  // Taps lean toward the extremes so that the sum range gets exercised.
  function automatic logic [TAP_W-1:0] rand_tap();
    case ($urandom_range(0, 7))
      0: begin
        return 16'h7FFF;
      end
      1: begin
        return 16'h8000;
      end
      2: begin
        return 16'h0000;
      end
      3: begin
        return 16'hFFFF;
      end
      4: begin
        return 16'h0001;
      end
      default: begin
        return TAP_W'($urandom);
      end
    endcase
  endfunction

  function automatic logic [KROW_W-1:0] rand_kernel_row();
    return {rand_tap(), rand_tap(), rand_tap()};
  endfunction

  // Mostly small images; now and then a size below three to hit the clamp.
  function automatic logic [SIZE_W-1:0] pick_size();
    if ($urandom_range(0, 5) == 0) begin
      return SIZE_W'($urandom_range(0, 2));
    end
    return SIZE_W'($urandom_range(3, 10));
  endfunction

  // Size registers only look at the low bits, so the rest carries noise.
  function automatic logic [KROW_W-1:0] size_word(input logic [SIZE_W-1:0] v);
    return {5'($urandom), 32'($urandom), v};
  endfunction

  // Advances the filter copy by one accepted pixel and queues the result
  // that pixel produces, if any.
  task automatic filter_pixel(input logic [PIX_W-1:0] px, input logic restart);
    int w;
    int h;
    int slot;
    int acc;
    logic [PIX_W-1:0] top_px;
    logic [PIX_W-1:0] mid_px;
    window_result_t res;
    w = fit_dim(width_cfg, DEF_MAX_WIDTH);
    h = fit_dim(height_cfg, DEF_MAX_HEIGHT);
    if (restart) begin
      col_at = 0;
      row_at = 0;
    end
    // A width or height that shrank under the current position pushes it on.
    if (col_at >= w) begin
      col_at = 0;
      row_at++;
    end
    if (row_at >= h) begin
      row_at = 0;
    end
    slot = col_at % DEF_MAX_WIDTH;
    top_px = upper_line[slot];
    mid_px = lower_line[slot];
    for (int u = 0; u < 3; u++) begin
      win[u][0] = win[u][1];
      win[u][1] = win[u][2];
    end
    win[0][2] = top_px;
    win[1][2] = mid_px;
    win[2][2] = px;
    upper_line[slot] = mid_px;
    lower_line[slot] = px;
    upper_seen[slot] = lower_seen[slot];
    lower_seen[slot] = 1'b1;
    if (row_at >= 2 && col_at >= 2) begin
      acc = 0;
      // Correlation order: tap (0,0) weights the oldest pixel of the window.
      for (int u = 0; u < 3; u++) begin
        for (int v = 0; v < 3; v++) begin
          acc += int'(win[u][v]) * int'($signed(taps_row[u][v*TAP_W +: TAP_W]));
        end
      end
      res.sum = SUM_W'(acc);
      res.row = IDX_W'(row_at - 2);
      res.col = IDX_W'(col_at - 2);
      res.last = (row_at == h - 1 && col_at == w - 1);
      sums_due.push_back(res);
    end
    col_at++;
    if (col_at >= w) begin
      col_at = 0;
      row_at++;
      if (row_at >= h) begin
        row_at = 0;
      end
    end
  endtask

  // Writes one register and mirrors it once the write is taken. The valid
  // stays high on return so back-to-back writes follow without a gap; the
  // caller lowers it after the last write of a batch.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KROW_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      conv3_pkg::REG_KERNEL_TOP: begin
        taps_row[0] = val;
      end
      conv3_pkg::REG_KERNEL_MIDDLE: begin
        taps_row[1] = val;
      end
      conv3_pkg::REG_KERNEL_BOTTOM: begin
        taps_row[2] = val;
      end
      conv3_pkg::REG_IMAGE_WIDTH: begin
        width_cfg = val[SIZE_W-1:0];
      end
      conv3_pkg::REG_IMAGE_HEIGHT: begin
        height_cfg = val[SIZE_W-1:0];
      end
      default: begin
        // Indexes past the register list have no effect.
      end
    endcase
  endtask

  // Random pixels, with black and white overrepresented. A noisy run also
  // drops an occasional frame start into the middle of a frame.
  task automatic queue_pixels(input int count, input bit restart, input bit noisy);
    pixel_item_t item;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        item.px = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end else begin
        item.px = PIX_W'($urandom_range(0, 255));
      end
      item.fs = (i == 0) ? restart : (noisy && $urandom_range(0, 149) == 0);
      pixels_pending.push_back(item);
    end
  endtask

  // Waits until every pixel is taken and every result is back, then gives
  // the pipeline time to finish pixels that produce no result.
  task automatic settle();
    while (pixels_pending.size() != 0 || in_valid || sums_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
  endtask

  // Pixel driver. A new item is presented only when the slot is free, so the
  // payload holds steady while the block stalls. Each item draws the number
  // of idle cycles that precede the next one.
  always @(posedge clk) begin : pixel_feed
    int feed_wait;
    pixel_item_t next_item;
    if (rst) begin
      in_valid <= 1'b0;
      feed_wait = 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        filter_pixel(pixel, frame_start);
      end
      if (feed_wait > 0) begin
        feed_wait--;
        in_valid <= 1'b0;
      end else if (pixels_pending.size() != 0) begin
        next_item = pixels_pending.pop_front();
        in_valid <= 1'b1;
        pixel <= next_item.px;
        frame_start <= next_item.fs;
        feed_wait = steady_in ? 0 : $urandom_range(0, 12);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor with back-pressure: after each taken result, ready drops
  // for a random number of cycles.
  always @(posedge clk) begin : result_watch
    int hold_off;
    window_result_t due;
    if (rst) begin
      out_ready <= 1'b0;
      hold_off = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (sums_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result: sum %0d row %0d col %0d end %0b",
                     sum, out_row, out_col, frame_end);
          end
        end else begin
          due = sums_due.pop_front();
          if (sum !== due.sum || out_row !== due.row || out_col !== due.col ||
              frame_end !== due.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: expected sum %0d row %0d col %0d end %0b,",
                       due.sum, due.row, due.col, due.last,
                       " got sum %0d row %0d col %0d end %0b",
                       sum, out_row, out_col, frame_end);
            end
          end
        end
        hold_off = steady_out ? 0 : $urandom_range(0, 12);
      end
      if (hold_off > 0) begin
        hold_off--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    pixel_item_t item;
    int random_items;
    int w;
    int h;
    int c;
    int r;
    int count;
    int lead;
    bit mid_frame;
    bit restart;
    bit width_moved;

    for (int k = 0; k < 3; k++) begin
      taps_row[k] = '0;
    end
    width_cfg = conv3_pkg::SIZE_RESET;
    height_cfg = conv3_pkg::SIZE_RESET;
    for (int i = 0; i < DEF_MAX_WIDTH; i++) begin
      upper_seen[i] = 1'b0;
      lower_seen[i] = 1'b0;
    end
    for (int u = 0; u < 3; u++) begin
      for (int v = 0; v < 3; v++) begin
        win[u][v] = '0;
      end
    end
    col_at = 0;
    row_at = 0;
    mismatches = 0;
    random_items = 0;
    steady_in = 1'b0;
    steady_out = 1'b0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    settle();

    // Largest positive taps on an all-white image at the reset size of 5x5:
    // every result must be the top of the sum range.
    write_reg(conv3_pkg::REG_KERNEL_TOP, {3{16'h7FFF}});
    write_reg(conv3_pkg::REG_KERNEL_MIDDLE, {3{16'h7FFF}});
    write_reg(conv3_pkg::REG_KERNEL_BOTTOM, {3{16'h7FFF}});
    cfg_valid <= 1'b0;
    for (int i = 0; i < 25; i++) begin
      item.px = 8'hFF;
      item.fs = (i == 0);
      pixels_pending.push_back(item);
    end
    settle();

    // Most negative taps, sizes below the minimum (both clamp to three), and
    // writes past the register list that must change nothing. The frame
    // follows the last one without a frame start, so it relies on the wrap.
    steady_in = 1'b1;
    steady_out = 1'b1;
    write_reg(conv3_pkg::REG_KERNEL_TOP, {3{16'h8000}});
    write_reg(conv3_pkg::REG_KERNEL_MIDDLE, {3{16'h8000}});
    write_reg(conv3_pkg::REG_KERNEL_BOTTOM, {3{16'h8000}});
    write_reg(conv3_pkg::REG_IMAGE_WIDTH, size_word(11'd0));
    write_reg(conv3_pkg::REG_IMAGE_HEIGHT, size_word(11'd2));
    for (int i = int'(conv3_pkg::REG_IMAGE_HEIGHT) + 1; i < (1 << CFG_IDX_W); i++) begin
      write_reg(CFG_IDX_W'(i), {16'($urandom), 32'($urandom)});
    end
    cfg_valid <= 1'b0;
    for (int i = 0; i < 9; i++) begin
      item.px = 8'hFF;
      item.fs = 1'b0;
      pixels_pending.push_back(item);
    end
    settle();

    // Random phases on small images. Each phase may rewrite any register.
    // Most phases run whole frames; some stop inside a frame so that the next
    // phase resizes under a live position. Such a resize keeps going without
    // a frame start only when every line entry it can reach holds a pixel.
    while (random_items < 500) begin
      settle();
      steady_in = ($urandom_range(0, 3) == 0);
      steady_out = ($urandom_range(0, 3) == 0);
      mid_frame = (row_at != 0 || col_at != 0);
      width_moved = 1'b0;
      if ($urandom_range(0, 1)) begin
        write_reg(conv3_pkg::REG_KERNEL_TOP, rand_kernel_row());
      end
      if ($urandom_range(0, 1)) begin
        write_reg(conv3_pkg::REG_KERNEL_MIDDLE, rand_kernel_row());
      end
      if ($urandom_range(0, 1)) begin
        write_reg(conv3_pkg::REG_KERNEL_BOTTOM, rand_kernel_row());
      end
      if ($urandom_range(0, 2) != 0) begin
        write_reg(conv3_pkg::REG_IMAGE_WIDTH, size_word(pick_size()));
        width_moved = 1'b1;
      end
      if ($urandom_range(0, 2) != 0) begin
        write_reg(conv3_pkg::REG_IMAGE_HEIGHT, size_word(pick_size()));
      end
      if ($urandom_range(0, 4) == 0) begin
        write_reg(CFG_IDX_W'($urandom_range(int'(conv3_pkg::REG_IMAGE_HEIGHT) + 1,
                                            (1 << CFG_IDX_W) - 1)),
                  {16'($urandom), 32'($urandom)});
      end
      cfg_valid <= 1'b0;

      w = fit_dim(width_cfg, DEF_MAX_WIDTH);
      h = fit_dim(height_cfg, DEF_MAX_HEIGHT);
      lead = 0;
      while (lead < DEF_MAX_WIDTH && upper_seen[lead]) begin
        lead++;
      end
      restart = mid_frame && width_moved && w > lead;
      if (!mid_frame && $urandom_range(0, 1)) begin
        restart = 1'b1;
      end

      // Finish the frame in progress (as the new sizes see it), add whole
      // frames, and sometimes a partial frame to leave the next phase mid way.
      c = restart ? 0 : col_at;
      r = restart ? 0 : row_at;
      if (c >= w) begin
        c = 0;
        r++;
      end
      if (r >= h) begin
        r = 0;
      end
      count = (r == 0 && c == 0) ? 0 : w * h - (r * w + c);
      count += $urandom_range(0, 2) * w * h;
      if ($urandom_range(0, 3) == 0) begin
        count += $urandom_range(1, w * h - 1);
      end
      if (count == 0) begin
        count = w * h;
      end
      queue_pixels(count, restart, 1'b1);
      random_items += count;
    end

    // Wide rows: one frame of three rows of a hundred pixels reaches column
    // indexes far past the small random sizes.
    settle();
    steady_in = 1'b0;
    steady_out = 1'b0;
    write_reg(conv3_pkg::REG_KERNEL_TOP, rand_kernel_row());
    write_reg(conv3_pkg::REG_KERNEL_MIDDLE, rand_kernel_row());
    write_reg(conv3_pkg::REG_KERNEL_BOTTOM, rand_kernel_row());
    write_reg(conv3_pkg::REG_IMAGE_WIDTH, size_word(11'd100));
    write_reg(conv3_pkg::REG_IMAGE_HEIGHT, size_word(11'd3));
    cfg_valid <= 1'b0;
    queue_pixels(300, 1'b1, 1'b0);

    // Tall image: the height register is all ones and clamps to the maximum,
    // so eighty rows of three pixels run on without reaching the frame end.
    settle();
    steady_in = 1'b1;
    write_reg(conv3_pkg::REG_IMAGE_WIDTH, size_word(11'd3));
    write_reg(conv3_pkg::REG_IMAGE_HEIGHT, size_word(11'h7FF));
    cfg_valid <= 1'b0;
    queue_pixels(3 * 80, 1'b1, 1'b0);

    settle();
    if (mismatches == 0 && sums_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/conv3_pkg.sv
rtl/core/conv3_line_store.sv
rtl/core/conv3_cell.sv
rtl/core/convolution_3x3_valid_top.sv
test/convolution_3x3_valid_top_test.sv
